@@ rtl/naca4_pkg.sv @@
// Shared widths and fixed-point constants of the NACA four-digit surface point unit.
package naca4_pkg;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned IFRAC     = 30;
  localparam int unsigned IN_W      = FRAC_BITS + 1;
  localparam int unsigned OUT_W     = FRAC_BITS + 2;
  localparam int unsigned CODE_W    = 14;
  localparam int unsigned XW        = IFRAC + 1;

  localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(9999);
  localparam logic [3:0]        RST_MM     = 4'd4;
  localparam logic [3:0]        RST_PP     = 4'd4;
  localparam logic [6:0]        RST_TT     = 7'd12;

endpackage

@@ rtl/naca4_isqrt.sv @@
// Pipelined floored integer square root, one root bit per stage, with sideband.
module naca4_isqrt #(
  parameter int unsigned RW     = 31,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [SIDE_W-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              v_in;
    logic [RW+1:0]     rem_in;
    logic [RW-1:0]     root_in;
    logic [2*RW-1:0]   rad_in;
    logic [SIDE_W-1:0] s_in;
    logic [RW+2:0]     rem_sh;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign s_in    = side_q[k-1];
    end

    assign rem_sh = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= s_in;
      rad_q[k]  <= rad_in << 2;
      if (rem_sh >= trial) begin
        rem_q[k]  <= diff[RW+1:0];
        root_q[k] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_sh[RW+1:0];
        root_q[k] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

@@ rtl/naca4_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
module naca4_div #(
  parameter int unsigned NW     = 49,
  parameter int unsigned DW     = 18,
  parameter int unsigned QW     = 32,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NW-1:0] num_hi;
  assign num_hi = num_i >> QW;

  logic              vld_q  [QW];
  logic [DW-1:0]     rem_q  [QW];
  logic [QW-1:0]     lo_q   [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [DW-1:0]     den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [QW-1:0]     lo_in;
    logic [QW-1:0]     quo_in;
    logic [DW-1:0]     den_in;
    logic [SIDE_W-1:0] s_in;
    logic [DW:0]       rem_sh;
    logic [DW:0]       diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_hi[DW-1:0];
      assign lo_in  = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign rem_sh = {rem_in, lo_in[QW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};
    assign diff   = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= s_in;
      den_q[k]  <= den_in;
      lo_q[k]   <= lo_in << 1;
      quo_q[k]  <= {quo_in[QW-2:0], ge};
      rem_q[k]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

@@ rtl/naca4_airfoil_surface_point_unit.sv @@
// NACA four-digit airfoil surface point unit: fully pipelined top level.
// One beat per cycle in.
// Throughput: one chord position per cycle; busy_o stays low, the pipeline never stalls.
// The depth is set by two 31/32-stage square roots and two 32/31-stage dividers.
// Reset clears all valid bits and loads airfoil code 4412; the receiver cannot stall.
module naca4_airfoil_surface_point_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [naca4_pkg::CODE_W-1:0]            cfg_data_i,
  input  logic                                    start_i,
  input  logic [naca4_pkg::IN_W-1:0]              chord_position_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic signed [naca4_pkg::OUT_W-1:0]      upper_x_o,
  output logic signed [naca4_pkg::OUT_W-1:0]      upper_y_o,
  output logic signed [naca4_pkg::OUT_W-1:0]      lower_x_o,
  output logic signed [naca4_pkg::OUT_W-1:0]      lower_y_o,
  output logic                                    out_of_range_o
);
  import naca4_pkg::*;

  localparam int unsigned PW    = 44;
  localparam int unsigned CW    = 36;
  localparam int unsigned NUMW  = 38;
  localparam int unsigned DENW  = 9;
  localparam int unsigned YTNW  = 49;
  localparam int unsigned DQW   = 32;
  localparam int unsigned RW2   = 32;
  localparam int unsigned CQW   = 31;
  localparam int unsigned SW    = 34;
  localparam int unsigned LAT   = 2 + XW + 5 + DQW + 1 + RW2 + CQW + 3;
  localparam int unsigned YT_SH = 6;
  localparam int unsigned YMW   = YTNW - YT_SH;
  localparam int unsigned YLO   = 22;
  localparam int unsigned YPW   = 2 * YLO;
  localparam int unsigned YT_K  = 55;
  localparam int unsigned YSW   = YT_K + DQW;
  localparam logic [YPW-1:0] YT_RECIP = YPW'(64'd11529215046069);
  localparam logic signed [SW-1:0] OUT_HI = SW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SW-1:0] OUT_LO = -OUT_HI - SW'(1);
  localparam logic signed [SW-1:0] HALF   = SW'(1 << (IFRAC - FRAC_BITS - 1));

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] x2;
    logic          oor;
  } sq1_side_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic          oor;
    logic          dneg;
  } dv_side_t;

  typedef struct packed {
    logic [XW-1:0] yt;
    logic [XW-1:0] yc;
    logic [XW-1:0] ad;
    logic [XW-1:0] x;
    logic          oor;
    logic          dneg;
  } sq2_side_t;

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] q;
    a = v + HALF;
    q = a >>> (IFRAC - FRAC_BITS);
    if (q > OUT_HI) begin
      q = OUT_HI;
    end else if (q < OUT_LO) begin
      q = OUT_LO;
    end
    return q[OUT_W-1:0];
  endfunction

  // configuration: decode the decimal code into digits on the write
  logic [CODE_W-1:0] code_sat;
  logic [3:0]        mm_d, pp_d, mm_q, pp_q, pq_d;
  logic [9:0]        rem1_d;
  logic [6:0]        tt_d, tt_q;
  logic [DENW-1:0]   den_f_d, den_r_d, den_f_q, den_r_q;
  logic              czero_q;

  always_comb begin
    code_sat = (cfg_data_i > CODE_MAX) ? CODE_MAX : cfg_data_i;
    mm_d = '0;
    for (int i = 1; i < 10; i++) begin
      if (code_sat >= CODE_W'(i * 1000)) begin
        mm_d = 4'(i);
      end
    end
    rem1_d = 10'(code_sat - CODE_W'(mm_d) * CODE_W'(1000));
    pp_d = '0;
    for (int i = 1; i < 10; i++) begin
      if (rem1_d >= 10'(i * 100)) begin
        pp_d = 4'(i);
      end
    end
    tt_d    = 7'(rem1_d - 10'(pp_d) * 10'd100);
    pq_d    = 4'd10 - pp_d;
    den_f_d = DENW'(5) * (DENW'(pp_d) * DENW'(pp_d));
    den_r_d = DENW'(5) * (DENW'(pq_d) * DENW'(pq_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q    <= RST_MM;
      pp_q    <= RST_PP;
      tt_q    <= RST_TT;
      den_f_q <= DENW'(80);
      den_r_q <= DENW'(180);
      czero_q <= 1'b0;
    end else if (cfg_we_i) begin
      mm_q    <= mm_d;
      pp_q    <= pp_d;
      tt_q    <= tt_d;
      den_f_q <= den_f_d;
      den_r_q <= den_r_d;
      czero_q <= (mm_d == 4'd0) || (pp_d == 4'd0);
    end
  end

  assign busy_o = 1'b0;

  // S1: widen x to Q30, flag positions above one
  logic          s1_v_q, s1_oor_q;
  logic [XW-1:0] s1_x_q;
  logic          in_oor;
  assign in_oor = chord_position_i > (IN_W'(1) << FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i && !busy_o;
    end
  end
  always_ff @(posedge clk_i) begin
    s1_oor_q <= in_oor;
    s1_x_q   <= in_oor ? '0 : XW'(chord_position_i) << (IFRAC - FRAC_BITS);
  end

  // S2: x^2
  logic          s2_v_q, s2_oor_q;
  logic [XW-1:0] s2_x_q, s2_x2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s2_oor_q <= s1_oor_q;
    s2_x_q   <= s1_x_q;
    s2_x2_q  <= XW'((2*XW)'((2*XW)'(s1_x_q) * (2*XW)'(s1_x_q)) >> IFRAC);
  end

  // sqrt(x) in Q30
  sq1_side_t     sq1_side_in, sq1_side_out;
  logic          sq1_v;
  logic [XW-1:0] sq1_root;
  assign sq1_side_in = '{x: s2_x_q, x2: s2_x2_q, oor: s2_oor_q};

  naca4_isqrt #(.RW(XW), .SIDE_W($bits(sq1_side_t))) u_sqrt_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_v_q),
    .rad_i   ((2*XW)'(s2_x_q) << IFRAC),
    .side_i  (sq1_side_in),
    .valid_o (sq1_v),
    .root_o  (sq1_root),
    .side_o  (sq1_side_out)
  );

  // S3, S4: x^3, x^4
  logic          s3_v_q, s3_oor_q, s4_v_q, s4_oor_q;
  logic [XW-1:0] s3_s_q, s3_x_q, s3_x2_q, s3_x3_q;
  logic [XW-1:0] s4_s_q, s4_x_q, s4_x2_q, s4_x3_q, s4_x4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s3_v_q <= sq1_v;
      s4_v_q <= s3_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s3_s_q   <= sq1_root;
    s3_x_q   <= sq1_side_out.x;
    s3_x2_q  <= sq1_side_out.x2;
    s3_oor_q <= sq1_side_out.oor;
    s3_x3_q  <= XW'((2*XW)'((2*XW)'(sq1_side_out.x2) * (2*XW)'(sq1_side_out.x)) >> IFRAC);
    s4_s_q   <= s3_s_q;
    s4_x_q   <= s3_x_q;
    s4_x2_q  <= s3_x2_q;
    s4_x3_q  <= s3_x3_q;
    s4_oor_q <= s3_oor_q;
    s4_x4_q  <= XW'((2*XW)'((2*XW)'(s3_x3_q) * (2*XW)'(s3_x_q)) >> IFRAC);
  end

  // S5: thickness terms and camber branch terms
  logic          s5_v_q, s5_oor_q, s5_rear_q;
  logic [PW-1:0] s5_pos_q, s5_neg_q;
  logic [CW-1:0] s5_cy_q, s5_cd_q;
  logic [XW-1:0] s5_x_q;
  logic          front;
  logic [CW-1:0] x10, p_one, px, x2_5, cy_d, cd_d;

  always_comb begin
    x10   = CW'(s4_x_q) * CW'(10);
    p_one = CW'(pp_q) << IFRAC;
    px    = CW'(pp_q) * CW'(s4_x_q);
    x2_5  = CW'(s4_x2_q) * CW'(5);
    front = x10 <= p_one;
    if (front) begin
      cy_d = px - x2_5;
      cd_d = p_one - x10;
    end else begin
      cy_d = (CW'(5) << IFRAC) + px - p_one - x2_5;
      cd_d = x10 - p_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s5_pos_q  <= PW'(s4_s_q) * PW'(2969) + PW'(s4_x3_q) * PW'(2843);
    s5_neg_q  <= PW'(s4_x_q) * PW'(1260) + PW'(s4_x2_q) * PW'(3516)
               + PW'(s4_x4_q) * PW'(1015);
    s5_cy_q   <= cy_d;
    s5_cd_q   <= cd_d;
    s5_rear_q <= !front;
    s5_x_q    <= s4_x_q;
    s5_oor_q  <= s4_oor_q;
  end

  // S6: polynomial sum, camber numerators and divisor
  logic            s6_v_q, s6_oor_q, s6_dneg_q;
  logic [PW:0]     s6_pnum_q;
  logic [NUMW-1:0] s6_yn_q, s6_dn_q;
  logic [DENW-1:0] s6_den_q;
  logic [XW-1:0]   s6_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= s5_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s6_pnum_q <= (PW+1)'(s5_pos_q) - (PW+1)'(s5_neg_q);
    s6_yn_q   <= czero_q ? '0 : NUMW'(CW'(mm_q) * s5_cy_q);
    s6_dn_q   <= czero_q ? '0 : NUMW'((NUMW)'(mm_q) * NUMW'(s5_cd_q));
    s6_den_q  <= czero_q ? DENW'(1) : (s5_rear_q ? den_r_q : den_f_q);
    s6_dneg_q <= s5_rear_q && !czero_q;
    s6_x_q    <= s5_x_q;
    s6_oor_q  <= s5_oor_q;
  end

  // S7: scale by thickness, clamp negative to zero
  logic            s7_v_q, s7_oor_q, s7_dneg_q;
  logic [YTNW-1:0] s7_ytn_q;
  logic [NUMW-1:0] s7_yn_q, s7_dn_q;
  logic [DENW-1:0] s7_den_q;
  logic [XW-1:0]   s7_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else begin
      s7_v_q <= s6_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s7_ytn_q  <= s6_pnum_q[PW] ? '0 : YTNW'(YTNW'(s6_pnum_q[PW-1:0]) * YTNW'(tt_q));
    s7_yn_q   <= s6_yn_q;
    s7_dn_q   <= s6_dn_q;
    s7_den_q  <= s6_den_q;
    s7_dneg_q <= s6_dneg_q;
    s7_x_q    <= s6_x_q;
    s7_oor_q  <= s6_oor_q;
  end

  // yc and |d| quotients
  dv_side_t       dv_side_in, dv_side_out;
  logic           dv_v;
  logic [DQW-1:0] dv_yt, dv_yc, dv_ad;
  assign dv_side_in = '{x: s7_x_q, oor: s7_oor_q, dneg: s7_dneg_q};

  naca4_div #(.NW(NUMW), .DW(DENW), .QW(DQW), .SIDE_W(1)) u_div_yc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_v_q),
    .num_i   (s7_yn_q),
    .den_i   (s7_den_q),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (dv_yc),
    .side_o  ()
  );

  naca4_div #(.NW(NUMW), .DW(DENW), .QW(DQW), .SIDE_W($bits(dv_side_t))) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_v_q),
    .num_i   (s7_dn_q),
    .den_i   (s7_den_q),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .quo_o   (dv_ad),
    .side_o  (dv_side_out)
  );

  // yt: drop the factor 64 of 200000, multiply by the reciprocal of 3125,
  // then hold in step with the divider stages
  logic [YMW-1:0] ym;
  logic [YPW-1:0] yt_hh_q, yt_hl_q, yt_lh_q, yt_ll_q;
  logic [YSW-1:0] yt_sum;
  logic [DQW-1:0] yt_dly_q [DQW-1];

  assign ym = s7_ytn_q[YTNW-1:YT_SH];

  always_ff @(posedge clk_i) begin
    yt_hh_q <= YPW'(ym[YMW-1:YLO]) * YPW'(YT_RECIP[YPW-1:YLO]);
    yt_hl_q <= YPW'(ym[YMW-1:YLO]) * YPW'(YT_RECIP[YLO-1:0]);
    yt_lh_q <= YPW'(ym[YLO-1:0]) * YPW'(YT_RECIP[YPW-1:YLO]);
    yt_ll_q <= YPW'(ym[YLO-1:0]) * YPW'(YT_RECIP[YLO-1:0]);
  end

  assign yt_sum = (YSW'(yt_hh_q) << YPW) + (YSW'(yt_hl_q) << YLO)
                + (YSW'(yt_lh_q) << YLO) + YSW'(yt_ll_q);

  always_ff @(posedge clk_i) begin
    yt_dly_q[0] <= yt_sum[YSW-1:YT_K];
    for (int k = 1; k < DQW - 1; k++) begin
      yt_dly_q[k] <= yt_dly_q[k-1];
    end
  end

  assign dv_yt = yt_dly_q[DQW-2];

  // S8: d^2
  logic          s8_v_q;
  logic [31:0]   s8_d2_q;
  sq2_side_t     s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else begin
      s8_v_q <= dv_v;
    end
  end
  always_ff @(posedge clk_i) begin
    s8_d2_q   <= 32'((2*XW)'((2*XW)'(dv_ad[XW-1:0]) * (2*XW)'(dv_ad[XW-1:0])) >> IFRAC);
    s8_side_q <= '{yt: dv_yt[XW-1:0], yc: dv_yc[XW-1:0], ad: dv_ad[XW-1:0],
                   x: dv_side_out.x, oor: dv_side_out.oor, dneg: dv_side_out.dneg};
  end

  // sqrt(1 + d^2) in Q30
  logic           sq2_v;
  logic [RW2-1:0] sq2_root;
  sq2_side_t      sq2_side_out;

  naca4_isqrt #(.RW(RW2), .SIDE_W($bits(sq2_side_t))) u_sqrt_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s8_v_q),
    .rad_i   ((2*RW2)'(33'(s8_d2_q) + (33'(1) << IFRAC)) << IFRAC),
    .side_i  (s8_side_q),
    .valid_o (sq2_v),
    .root_o  (sq2_root),
    .side_o  (sq2_side_out)
  );

  // cos and |sin| quotients
  logic           cs_v;
  logic [CQW-1:0] cs_cos, cs_sin;
  sq2_side_t      cs_side;

  naca4_div #(.NW(2*IFRAC+1), .DW(RW2), .QW(CQW), .SIDE_W($bits(sq2_side_t))) u_div_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq2_v),
    .num_i   ((2*IFRAC+1)'(1) << (2*IFRAC)),
    .den_i   (sq2_root),
    .side_i  (sq2_side_out),
    .valid_o (cs_v),
    .quo_o   (cs_cos),
    .side_o  (cs_side)
  );

  naca4_div #(.NW(2*IFRAC+1), .DW(RW2), .QW(CQW), .SIDE_W(1)) u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq2_v),
    .num_i   ((2*IFRAC+1)'(sq2_side_out.ad) << IFRAC),
    .den_i   (sq2_root),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (cs_sin),
    .side_o  ()
  );

  // S9: normal offsets
  logic          s9_v_q, s9_oor_q, s9_dneg_q;
  logic [31:0]   s9_offs_q, s9_offc_q;
  logic [XW-1:0] s9_x_q, s9_yc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else begin
      s9_v_q <= cs_v;
    end
  end
  always_ff @(posedge clk_i) begin
    s9_offs_q <= 32'((2*XW)'((2*XW)'(cs_side.yt) * (2*XW)'(cs_sin)) >> IFRAC);
    s9_offc_q <= 32'((2*XW)'((2*XW)'(cs_side.yt) * (2*XW)'(cs_cos)) >> IFRAC);
    s9_x_q    <= cs_side.x;
    s9_yc_q   <= cs_side.yc;
    s9_oor_q  <= cs_side.oor;
    s9_dneg_q <= cs_side.dneg;
  end

  // S10: surface points in Q30
  logic                 s10_v_q, s10_oor_q;
  logic signed [SW-1:0] s10_ux_q, s10_uy_q, s10_lx_q, s10_ly_q;
  logic signed [SW-1:0] xs, ycs, os, oc;

  always_comb begin
    xs  = $signed(SW'(s9_x_q));
    ycs = $signed(SW'(s9_yc_q));
    oc  = $signed(SW'(s9_offc_q));
    os  = s9_dneg_q ? -$signed(SW'(s9_offs_q)) : $signed(SW'(s9_offs_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_v_q <= 1'b0;
    end else begin
      s10_v_q <= s9_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s10_ux_q  <= xs - os;
    s10_uy_q  <= ycs + oc;
    s10_lx_q  <= xs + os;
    s10_ly_q  <= ycs - oc;
    s10_oor_q <= s9_oor_q;
  end

  // S11: round, saturate, drop coordinates out of range
  logic                    done_q, oor_q;
  logic signed [OUT_W-1:0] ux_q, uy_q, lx_q, ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s10_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    oor_q <= s10_oor_q;
    ux_q  <= s10_oor_q ? '0 : round_sat(s10_ux_q);
    uy_q  <= s10_oor_q ? '0 : round_sat(s10_uy_q);
    lx_q  <= s10_oor_q ? '0 : round_sat(s10_lx_q);
    ly_q  <= s10_oor_q ? '0 : round_sat(s10_ly_q);
  end

  assign done_o         = done_q;
  assign out_of_range_o = oor_q;
  assign upper_x_o      = ux_q;
  assign upper_y_o      = uy_q;
  assign lower_x_o      = lx_q;
  assign lower_y_o      = ly_q;

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result beat without a start beat at the pipeline depth");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |->
      (upper_x_o == '0 && upper_y_o == '0 && lower_x_o == '0 && lower_y_o == '0))
    else $error("out of range beat carries nonzero coordinates");

  a_upper_above_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_of_range_o) |-> (upper_y_o >= lower_y_o))
    else $error("upper surface below lower surface");

endmodule

@@ sim/naca4_airfoil_surface_point_unit_test.sv @@
// Self-checking testbench for the NACA four-digit airfoil surface point unit.
`timescale 1ns / 1ps

module naca4_airfoil_surface_point_unit_test;
  import naca4_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] upper_x;
    logic signed [OUT_W-1:0] upper_y;
    logic signed [OUT_W-1:0] lower_x;
    logic signed [OUT_W-1:0] lower_y;
    logic                    out_of_range;
  } surface_point_t;

  class surface_scoreboard;
    surface_point_t   pending_points[$];
    logic [CODE_W-1:0] code;
    int               mismatches;
    int               checked;

    function new();
      code = CODE_W'(4412);
      mismatches = 0;
      checked = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [OUT_W-1:0] round_sat(longint v);
      longint q;
      q = (v + 64'sd16384) >>> 15;
      if (q > 65535) q = 65535;
      if (q < -65536) q = -65536;
      return q[OUT_W-1:0];
    endfunction

    function void note_position(logic [IN_W-1:0] xr);
      surface_point_t  e;
      longint          one;
      longint          mm, pp, tt, X, pnum, yt, yc, d, sinq, offs, offc, den, q;
      longint unsigned cs, xq, x2, x3, x4, s, ad, d2, r, cosq, sinu;
      one = 64'sd1 <<< 30;
      cs = code > CODE_MAX ? 64'(CODE_MAX) : 64'(code);
      mm = longint'((cs / 1000) % 10);
      pp = longint'((cs / 100) % 10);
      tt = longint'(cs % 100);
      e = '0;
      if (xr > 17'd32768) begin
        e.out_of_range = 1'b1;
        pending_points.push_back(e);
        return;
      end
      xq = 64'(xr) << 15;
      x2 = (xq * xq) >> 30;
      x3 = (x2 * xq) >> 30;
      x4 = (x3 * xq) >> 30;
      s = int_sqrt(xq << 30);
      X = longint'(xq);
      pnum = 2969 * longint'(s) - 1260 * X - 3516 * longint'(x2)
           + 2843 * longint'(x3) - 1015 * longint'(x4);
      yt = pnum * tt / 200000;
      if (yt < 0) yt = 0;
      if (mm == 0 || pp == 0) begin
        yc = 0;
        d = 0;
      end else if (10 * X <= pp * one) begin
        den = 5 * pp * pp;
        yc = mm * (pp * X - 5 * longint'(x2)) / den;
        d = mm * (pp * one - 10 * X) / den;
      end else begin
        q = 10 - pp;
        den = 5 * q * q;
        yc = mm * ((5 - pp) * one + pp * X - 5 * longint'(x2)) / den;
        d = mm * (pp * one - 10 * X) / den;
      end
      ad = unsigned'(d < 0 ? -d : d);
      d2 = (ad * ad) >> 30;
      r = int_sqrt((unsigned'(one) + d2) << 30);
      cosq = (64'd1 << 60) / r;
      sinu = (ad << 30) / r;
      sinq = d < 0 ? -longint'(sinu) : longint'(sinu);
      offs = yt * sinq / one;
      offc = yt * longint'(cosq) / one;
      e.upper_x = round_sat(X - offs);
      e.upper_y = round_sat(yc + offc);
      e.lower_x = round_sat(X + offs);
      e.lower_y = round_sat(yc - offc);
      pending_points.push_back(e);
    endfunction

    function void check_point(surface_point_t got);
      surface_point_t e;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      e = pending_points.pop_front();
      checked++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch code %0d: expected %p got %p", code, e, got);
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CODE_W-1:0]       cfg_data_i;
  logic                    start_i;
  logic [IN_W-1:0]         chord_position_i;
  logic                    busy_o;
  logic                    done_o;
  logic signed [OUT_W-1:0] upper_x_o;
  logic signed [OUT_W-1:0] upper_y_o;
  logic signed [OUT_W-1:0] lower_x_o;
  logic signed [OUT_W-1:0] lower_y_o;
  logic                    out_of_range_o;

  surface_scoreboard sb;
  bit                idle_on;
  int                codes_used;

  naca4_airfoil_surface_point_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .chord_position_i (chord_position_i),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .upper_x_o        (upper_x_o),
    .upper_y_o        (upper_y_o),
    .lower_x_o        (lower_x_o),
    .lower_y_o        (lower_y_o),
    .out_of_range_o   (out_of_range_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_position(chord_position_i);
      if (done_o)
        sb.check_point({upper_x_o, upper_y_o, lower_x_o, lower_y_o, out_of_range_o});
    end
  end

  task automatic send_beat(logic [IN_W-1:0] x);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    chord_position_i <= x;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_code(logic [CODE_W-1:0] c);
    cfg_we_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.code = c;
    codes_used++;
  endtask

  function automatic logic [IN_W-1:0] rand_position();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return IN_W'($urandom_range(0, 32768));
    if (k == 7) return IN_W'($urandom_range(32760, 32776));
    return IN_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [CODE_W-1:0] codes[12];
    logic [IN_W-1:0]   directed[$];
    sb = new();
    idle_on = 1'b1;
    codes_used = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    start_i = 1'b0;
    chord_position_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{16'd0, 16'd1, 16'd2, 16'd13107, 16'd13108, 16'd16384, 16'd32767,
                 16'd32768, 16'd32769, 16'd65535, 16'h5555, 16'hAAAA, 16'd3277};
    foreach (directed[i]) send_beat(directed[i]);

    codes = '{14'd0, 14'd9999, 14'd16383, 14'd12, 14'd9100, 14'd9999 - 14'd0,
              14'd1001, 14'd2412, 14'd9199, 14'd10000, 14'd0, 14'd4412};
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      if (ph >= 5 && ph < 10 && ph != 7) codes[ph] = CODE_W'($urandom_range(0, 16383));
      write_code(codes[ph]);
      if (ph == 11) idle_on = 1'b0;
      foreach (directed[i]) if (i < 4) send_beat(directed[i]);
      repeat (133) send_beat(rand_position());
    end

    start_i <= 1'b0;
    fork
      while (sb.pending_points.size() != 0) @(posedge clk_i);
      begin
        repeat (20000) @(posedge clk_i);
        $display("timeout waiting for results");
        $display("tb: failure");
        $finish;
      end
    join_any
    disable fork;
    repeat (150) @(posedge clk_i);
    $display("checked %0d surface points over %0d airfoil codes, %0d mismatches",
             sb.checked, codes_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("run time limit reached");
    $display("tb: failure");
    $finish;
  end

endmodule

@@ naca4_airfoil_surface_point_unit.f @@
rtl/naca4_pkg.sv
rtl/naca4_isqrt.sv
rtl/naca4_div.sv
rtl/naca4_airfoil_surface_point_unit.sv
sim/naca4_airfoil_surface_point_unit_test.sv
